@@ design/cpsd_pkg.sv @@
// Package for the convex plane smooth distance core.
// Shared widths, defaults, config and command codes and the controller/datapath command and status structs.
package cpsd_pkg;

    localparam int MAX_PLANES_DEFAULT = 16;
    localparam int ACC_W = 72;
    localparam int CFG_ACTIVE = 0;
    localparam int CFG_RADIUS = 1;
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic write_plane;
        logic load_point;
        logic dot_step;
        logic dot_first;
        logic dist_done;
        logic fold_first;
        logic fold_eval;
        logic div_start;
        logic div_step;
        logic div_commit;
        logic fold_plain;
        logic emit;
    } cpsd_cmd_t;

    // Status back to the controller.
    typedef struct packed {
        logic need_div;
        logic div_done;
    } cpsd_stat_t;

endpackage

@@ design/cpsd_ram.sv @@
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module cpsd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ design/cpsd_datapath.sv @@
// Datapath: plane table, a 32x32 dot-product multiplier, fold logic and a radix-2 divider.
// Depends on cpsd_pkg and cpsd_ram.
module cpsd_datapath #(
    parameter int MAX_PLANES = cpsd_pkg::MAX_PLANES_DEFAULT
) (
    input  logic                          aclk,
    input  cpsd_pkg::cpsd_cmd_t           cmd,
    output cpsd_pkg::cpsd_stat_t          stat,
    input  logic [$clog2(MAX_PLANES)-1:0] wr_slot,
    input  logic [$clog2(MAX_PLANES)-1:0] rd_slot,
    input  logic [1:0]                    comp,
    input  logic [1:0]                    rd_comp,
    input  logic [127:0]                  plane_in,
    input  logic [95:0]                   point_in,
    input  logic [30:0]                   radius,
    output logic [31:0]                   dist_out,
    output logic                          sat_out
);
    import cpsd_pkg::*;

    localparam int AW = $clog2(MAX_PLANES);
    localparam int DW = 66;   // wide enough for 16..64 folded distances

    // Table: one RAM holds normals and offset at four words per plane.
    logic [AW+1:0] waddr_w, raddr_w;
    logic [31:0]   wdata_w, rdata_w;
    logic          we_w;

    assign we_w = cmd.write_plane;
    assign waddr_w = {wr_slot, comp};
    assign raddr_w = {rd_slot, rd_comp};
    always_comb begin
        case (comp)
            2'd0: wdata_w = plane_in[31:0];
            2'd1: wdata_w = plane_in[63:32];
            2'd2: wdata_w = plane_in[95:64];
            default: wdata_w = plane_in[127:96];
        endcase
    end

    cpsd_ram #(.WIDTH(32), .DEPTH(4 * MAX_PLANES)) u_ram (
        .aclk(aclk), .we(we_w), .waddr(waddr_w), .wdata(wdata_w),
        .raddr(raddr_w), .rdata(rdata_w)
    );

    // Point register.
    logic [95:0] point_reg;
    always_ff @(posedge aclk) if (cmd.load_point) point_reg <= point_in;

    // Product register after the multiplier, then accumulation.
    logic signed [31:0] pt_sel;
    logic signed [63:0] prod_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic [1:0] dcomp_reg;
    always_comb begin
        case (dcomp_reg)
            2'd0: pt_sel = point_reg[31:0];
            2'd1: pt_sel = point_reg[63:32];
            default: pt_sel = point_reg[95:64];
        endcase
    end
    logic signed [DW-1:0] di_reg, a_reg;
    logic signed [DW-1:0] rounded;
    assign rounded = DW'((acc_reg + ACC_W'(32'sh8000)) >>> 16);
    always_ff @(posedge aclk) begin
        if (cmd.dot_step) begin
            prod_reg <= $signed(rdata_w) * pt_sel;
            dcomp_reg <= dcomp_reg + 2'd1;
        end
        if (cmd.dot_first) begin
            acc_reg <= '0;
            dcomp_reg <= 2'd0;
        end else if (cmd.dot_step && dcomp_reg != 2'd0) begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
        if (cmd.dist_done) di_reg <= rounded - DW'($signed(rdata_w));
    end

    // Fold: max and |a-b|, then t = r - diff.
    logic signed [DW-1:0] mx_reg, diff_reg, t_c;
    always_ff @(posedge aclk) begin
        if (cmd.fold_eval) begin
            mx_reg <= (a_reg > di_reg) ? a_reg : di_reg;
            diff_reg <= (a_reg > di_reg) ? a_reg - di_reg : di_reg - a_reg;
        end
    end
    assign t_c = DW'({1'b0, radius}) - diff_reg;
    assign stat.need_div = (radius != '0) && (t_c > 0);

    // Divider: (t*t + 2r) / 4r, t < 2^31 so t*t below 2^62.
    logic [63:0] num_reg, rem_reg, quo_reg;
    logic [32:0] den;
    logic [6:0]  dcnt_reg;
    logic [64:0] trial;
    assign den = {radius, 2'b00};
    assign trial = {rem_reg, num_reg[63]} - {32'd0, den};
    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            num_reg <= 64'(t_c[31:0]) * 64'(t_c[31:0]) + {32'd0, radius, 1'b0};
            rem_reg <= '0;
            quo_reg <= '0;
            dcnt_reg <= 7'd64;
        end else if (cmd.div_step) begin
            if (!trial[64]) rem_reg <= trial[63:0];
            else rem_reg <= {rem_reg[62:0], num_reg[63]};
            quo_reg <= {quo_reg[62:0], !trial[64]};
            num_reg <= {num_reg[62:0], 1'b0};
            dcnt_reg <= dcnt_reg - 7'd1;
        end
        // Running fold value: first plane, rounded step or plain maximum.
        if (cmd.div_commit) a_reg <= mx_reg + DW'(quo_reg);
        else if (cmd.fold_plain) a_reg <= mx_reg;
        else if (cmd.fold_first) a_reg <= di_reg;
    end
    assign stat.div_done = (dcnt_reg == 7'd0);

    // Saturated output register.
    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            if (a_reg > DW'(64'sh7FFFFFFF)) begin
                dist_out <= 32'h7FFFFFFF; sat_out <= 1'b1;
            end else if (a_reg < -DW'(64'sh80000000)) begin
                dist_out <= 32'h80000000; sat_out <= 1'b1;
            end else begin
                dist_out <= a_reg[31:0]; sat_out <= 1'b0;
            end
        end
    end
endmodule

@@ design/cpsd_ctrl.sv @@
// Controller: sequences table writes, dot products, smooth folding and result handoff.
// Depends on cpsd_pkg.
module cpsd_ctrl #(
    parameter int MAX_PLANES = cpsd_pkg::MAX_PLANES_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          in_cmd,
    input  logic [3:0]                    in_slot,
    input  logic [4:0]                    active,
    output logic                          out_valid,
    input  logic                          out_ready,
    output cpsd_pkg::cpsd_cmd_t           cmd,
    input  cpsd_pkg::cpsd_stat_t          stat,
    output logic [$clog2(MAX_PLANES)-1:0] wr_slot,
    output logic [$clog2(MAX_PLANES)-1:0] rd_slot,
    output logic [1:0]                    comp,
    output logic [1:0]                    rd_comp
);
    import cpsd_pkg::*;

    localparam int AW = $clog2(MAX_PLANES);
    localparam logic [3:0] S_IDLE = 4'd0, S_WR = 4'd1, S_RD = 4'd2, S_MUL = 4'd3,
        S_DIST = 4'd4, S_FOLD = 4'd5, S_EVAL = 4'd6, S_DIV = 4'd7, S_EMIT = 4'd8;

    logic [3:0]  state_reg, state_next;
    logic [AW-1:0] slot_reg;
    logic [1:0]  comp_reg;
    logic [2:0]  step_reg;
    logic [AW:0] plane_reg;
    logic        out_valid_reg;
    logic [6:0]  count_lim;
    logic        emit_go;

    assign count_lim = (active == 5'd0) ? 7'd1 :
                       (7'(active) > 7'(MAX_PLANES)) ? 7'(MAX_PLANES) : 7'(active);
    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign wr_slot = slot_reg;
    assign comp = comp_reg;
    assign rd_slot = plane_reg[AW-1:0];
    assign emit_go = !out_valid_reg || out_ready;

    // The read address runs one component ahead of the multiply.
    always_comb begin
        rd_comp = step_reg[1:0];
        if (step_reg > 3'd3) rd_comp = 2'd3;
    end

    always_comb begin
        cmd = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (in_valid) begin
                if (in_cmd == CMD_QUERY) begin
                    cmd.load_point = 1'b1;
                    state_next = S_RD;
                end else if (32'(in_slot) < MAX_PLANES) begin
                    state_next = S_WR;
                end
            end
            S_WR: begin
                cmd.write_plane = 1'b1;
                if (comp_reg == 2'd3) state_next = S_IDLE;
            end
            S_RD: begin
                cmd.dot_first = 1'b1;
                state_next = S_MUL;
            end
            S_MUL: begin
                // steps 1..3 multiply x,y,z; step 4 adds z; step 4 also sees offset.
                cmd.dot_step = (step_reg >= 3'd1) && (step_reg <= 3'd4);
                if (step_reg == 3'd4) state_next = S_DIST;
            end
            S_DIST: begin
                cmd.dist_done = 1'b1;
                state_next = S_FOLD;
            end
            S_FOLD: begin
                if (plane_reg == '0) begin
                    cmd.fold_first = 1'b1;
                    state_next = (7'(plane_reg) + 7'd1 >= count_lim) ? S_EMIT : S_RD;
                end else begin
                    cmd.fold_eval = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL: begin
                if (stat.need_div) begin
                    cmd.div_start = 1'b1;
                    state_next = S_DIV;
                end else begin
                    cmd.fold_plain = 1'b1;
                    state_next = (7'(plane_reg) + 7'd1 >= count_lim) ? S_EMIT : S_RD;
                end
            end
            S_DIV: begin
                if (stat.div_done) begin
                    cmd.div_commit = 1'b1;
                    state_next = (7'(plane_reg) + 7'd1 >= count_lim) ? S_EMIT : S_RD;
                end else begin
                    cmd.div_step = 1'b1;
                end
            end
            S_EMIT: if (emit_go) begin
                cmd.emit = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
            comp_reg <= '0;
            step_reg <= '0;
            plane_reg <= '0;
            slot_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (cmd.emit) out_valid_reg <= 1'b1;
            else if (out_ready) out_valid_reg <= 1'b0;
            if (state_reg == S_IDLE) begin
                slot_reg <= AW'(in_slot);
                comp_reg <= '0;
                plane_reg <= '0;
            end
            if (state_reg == S_WR) comp_reg <= comp_reg + 2'd1;
            if (state_reg == S_RD) step_reg <= 3'd1;
            else if (state_reg == S_MUL) step_reg <= step_reg + 3'd1;
            else step_reg <= '0;
            if ((cmd.fold_first || cmd.fold_plain || cmd.div_commit)
                && state_next == S_RD) plane_reg <= plane_reg + 1'b1;
        end
    end
endmodule

@@ design/convex_planes_smooth_distance_core.sv @@
// Top level of the convex plane smooth distance core.
// Depends on cpsd_pkg, cpsd_ctrl, cpsd_datapath and cpsd_ram.
//
// Channel  Dir  Word contents
// s_       in   tdata: plane_slot, normal_x/y/z, plane_offset, point_x/y/z; tuser: command
// m_       out  tdata: distance; tuser: saturated
// cfg_     in   index 0 active_planes, index 1 smooth_radius
//
// A plane write stores the normal and offset words one after another. A query multiplies
// and folds one plane after another; a rounded fold runs the one-bit-a-step divider.
// Reset is synchronous and clears control; the plane table holds garbage until
// written. A waiting result holds the controller in its emit state until the word is taken.
module convex_planes_smooth_distance_core #(
    parameter int MAX_PLANES = cpsd_pkg::MAX_PLANES_DEFAULT
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [231:0] s_tdata,  // plane_slot, normal_x, normal_y, normal_z,
                                   // plane_offset, point_x, point_y, point_z
    input  logic         s_tuser,  // command
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [31:0]  m_tdata,  // distance
    output logic         m_tuser,  // saturated
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_index,
    input  logic [31:0]  cfg_data
);
    import cpsd_pkg::*;

    localparam int AW = $clog2(MAX_PLANES);

    logic [4:0]  active_reg;
    logic [30:0] radius_reg;
    logic [127:0] plane_reg;
    cpsd_cmd_t  cmd;
    cpsd_stat_t stat;
    logic [AW-1:0] wr_slot, rd_slot;
    logic [1:0] comp, rd_comp;

    // Configuration registers.
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 5'd1;
            radius_reg <= '0;
        end else if (cfg_valid) begin
            if (cfg_index == 1'(CFG_ACTIVE)) active_reg <= cfg_data[4:0];
            else radius_reg <= cfg_data[30:0];
        end
    end

    // Hold the plane word while it is written out to the table.
    always_ff @(posedge aclk) if (s_tvalid && s_tready) plane_reg <= s_tdata[131:4];

    cpsd_ctrl #(.MAX_PLANES(MAX_PLANES)) u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .in_valid(s_tvalid), .in_ready(s_tready),
        .in_cmd(s_tuser), .in_slot(s_tdata[3:0]), .active(active_reg),
        .out_valid(m_tvalid), .out_ready(m_tready), .cmd(cmd), .stat(stat),
        .wr_slot(wr_slot), .rd_slot(rd_slot), .comp(comp), .rd_comp(rd_comp)
    );

    cpsd_datapath #(.MAX_PLANES(MAX_PLANES)) u_dp (
        .aclk(aclk), .cmd(cmd), .stat(stat), .wr_slot(wr_slot), .rd_slot(rd_slot),
        .comp(comp), .rd_comp(rd_comp), .plane_in(plane_reg),
        .point_in(s_tdata[227:132]), .radius(radius_reg),
        .dist_out(m_tdata), .sat_out(m_tuser)
    );
endmodule

@@ dv/convex_planes_smooth_distance_core_test.sv @@
// Self-checking testbench for convex_planes_smooth_distance_core.
// Depends on cpsd_pkg and the core; predicts plane table writes and smoothed
// distance queries, and checks every result word in order.
`timescale 1ns / 100ps

module convex_planes_smooth_distance_core_test;
    import cpsd_pkg::*;

    typedef struct {
        logic               cmd;
        logic [3:0]         slot;
        logic signed [31:0] nx, ny, nz, ofs;
        logic signed [31:0] px, py, pz;
    } plane_op_t;

    typedef struct {
        logic signed [31:0] distance;
        logic               sat;
    } dist_word_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [231:0] s_tdata = '0;  // plane_slot, normal_x, normal_y, normal_z,
                                 // plane_offset, point_x, point_y, point_z
    logic         s_tuser = 1'b0;  // command
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [31:0]  m_tdata;  // distance
    logic         m_tuser;  // saturated
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic         cfg_index = 1'b0;
    logic [31:0]  cfg_data = '0;

    // Shadow copy of the plane table and registers.
    logic signed [31:0] tbl_n [16][3];
    logic signed [31:0] tbl_ofs [16];
    logic [4:0]         plane_count = 5'd1;
    logic [30:0]        round_radius = '0;

    plane_op_t  op_queue [$];
    dist_word_t dist_expected [$];
    plane_op_t  cur_op;
    int         send_idle = 0;
    int         recv_idle = 0;
    int         errors = 0;

    convex_planes_smooth_distance_core uut (.*);

    always #5 aclk = ~aclk;

    // Exact dot product rounded half up to Q16.16, minus the offset.
    function automatic logic signed [71:0] plane_dist(int k, plane_op_t q);
        logic signed [71:0] acc;
        acc = 72'(tbl_n[k][0]) * 72'(q.px) + 72'(tbl_n[k][1]) * 72'(q.py)
            + 72'(tbl_n[k][2]) * 72'(q.pz) + 72'sd32768;
        return (acc >>> 16) - 72'(tbl_ofs[k]);
    endfunction

    // Polynomial smooth maximum; a zero radius gives the plain maximum.
    function automatic logic signed [71:0] soft_max(logic signed [71:0] a,
                                                    logic signed [71:0] b);
        logic signed [71:0] m, diff, t;
        logic [71:0]        term;
        m = (a > b) ? a : b;
        diff = (a > b) ? a - b : b - a;
        t = 72'(round_radius) - diff;
        if (round_radius == 0 || t <= 0) return m;
        term = (72'(t) * 72'(t) + 72'(round_radius) * 2) / (72'(round_radius) * 4);
        return m + $signed(term);
    endfunction

    // Apply one accepted word to the shadow state.
    function automatic void predict_distance(plane_op_t q);
        logic signed [71:0] d;
        int                 n;
        dist_word_t         w;
        if (q.cmd == CMD_WRITE) begin
            tbl_n[q.slot][0] = q.nx;
            tbl_n[q.slot][1] = q.ny;
            tbl_n[q.slot][2] = q.nz;
            tbl_ofs[q.slot] = q.ofs;
            return;
        end
        n = (plane_count == 0) ? 1 : (plane_count > 16) ? 16 : plane_count;
        d = plane_dist(0, q);
        for (int k = 1; k < n; k++) d = soft_max(d, plane_dist(k, q));
        w.sat = 1'b1;
        if (d > 72'sd2147483647) w.distance = 32'sh7fffffff;
        else if (d < -72'sd2147483648) w.distance = 32'sh80000000;
        else begin
            w.distance = d[31:0];
            w.sat = 1'b0;
        end
        dist_expected.push_back(w);
    endfunction

    // Input driver: predicts on acceptance, then offers the next word.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) predict_distance(cur_op);
            if (!s_tvalid || s_tready) begin
                if (op_queue.size() > 0 && $urandom_range(99) >= send_idle) begin
                    cur_op = op_queue.pop_front();
                    s_tdata <= {4'b0, cur_op.pz, cur_op.py, cur_op.px, cur_op.ofs,
                                cur_op.nz, cur_op.ny, cur_op.nx, cur_op.slot};
                    s_tuser <= cur_op.cmd;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and random back-pressure.
    always @(posedge aclk) begin
        dist_word_t w;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (dist_expected.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected result word %h", m_tdata);
                end else begin
                    w = dist_expected.pop_front();
                    if (m_tdata !== w.distance || m_tuser !== w.sat) begin
                        errors++;
                        if (errors <= 10)
                            $display("distance mismatch: expected %h sat %b, got %h sat %b",
                                     w.distance, w.sat, m_tdata, m_tuser);
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    task automatic write_reg(logic idx, logic [31:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        if (idx == CFG_ACTIVE) plane_count = value[4:0];
        else round_radius = value[30:0];
    endtask

    // Coordinates either spread over the whole range or near the origin.
    function automatic logic signed [31:0] coord(bit wide);
        if (wide) return $urandom;
        return $signed($urandom_range(32'h80000)) - 32'sh40000;
    endfunction

    function automatic plane_op_t rand_op();
        plane_op_t q;
        bit        wide;
        wide = ($urandom_range(3) == 0);
        q.cmd = ($urandom_range(9) < 4) ? CMD_WRITE : CMD_QUERY;
        q.slot = 4'($urandom_range(15));
        q.nx = coord(wide);
        q.ny = coord(wide);
        q.nz = coord(wide);
        q.ofs = coord(wide);
        q.px = coord(wide);
        q.py = coord(wide);
        q.pz = coord(wide);
        return q;
    endfunction

    task automatic drain();
        do @(negedge aclk);
        while (op_queue.size() > 0 || s_tvalid || dist_expected.size() > 0);
        repeat (50) @(posedge aclk);
    endtask

    initial begin
        plane_op_t   q;
        logic [31:0] counts [7];
        logic [31:0] radii [7];
        counts = '{32'd1, 32'd16, 32'd4, 32'd0, 32'd31, 32'd3, 32'd2};
        radii = '{32'h0, 32'h0, 32'h7fffffff, 32'h1, 32'hffffffff,
                  $urandom_range(32'h40000), 32'h20000};
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        for (int ph = 0; ph < 7; ph++) begin
            send_idle = (ph < 2) ? 19 : (ph < 4) ? 77 : 0;
            recv_idle = (ph < 2) ? 77 : (ph < 4) ? 19 : 0;
            write_reg(CFG_ACTIVE, counts[ph]);
            write_reg(CFG_RADIUS, radii[ph]);
            if (ph == 0) begin
                // Fill every slot first, with full-scale corners in a few.
                for (int s = 0; s < 16; s++) begin
                    q = rand_op();
                    q.cmd = CMD_WRITE;
                    q.slot = 4'(s);
                    if (s == 0) {q.nx, q.ny, q.nz, q.ofs} = {4{32'sh7fffffff}};
                    if (s == 1) {q.nx, q.ny, q.nz, q.ofs} = {4{32'sh80000000}};
                    if (s == 2) {q.nx, q.ny, q.nz, q.ofs} = '0;
                    op_queue.push_back(q);
                end
                // Extreme points: positive and negative overflow, zero and a mixed corner.
                q.cmd = CMD_QUERY;
                {q.px, q.py, q.pz} = {3{32'sh80000000}};
                op_queue.push_back(q);
                {q.px, q.py, q.pz} = {3{32'sh7fffffff}};
                op_queue.push_back(q);
                {q.px, q.py, q.pz} = '0;
                op_queue.push_back(q);
                {q.px, q.py, q.pz} = {32'sh7fffffff, 32'sh80000000, 32'sh00010000};
                op_queue.push_back(q);
            end
            for (int i = 0; i < 190; i++) op_queue.push_back(rand_op());
            drain();
        end

        if (errors == 0 && dist_expected.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #100ms;
        $display("status: fail");
        $finish;
    end

endmodule
